// ----- design/rotary_slew_rate_controller_core_defines.svh -----
// assertion macros for the rotary slew rate controller checker
// expects signals named clock and reset in the scope of use
`ifndef ROTARY_SLEW_RATE_CONTROLLER_CORE_DEFINES_SVH
`define ROTARY_SLEW_RATE_CONTROLLER_CORE_DEFINES_SVH

// same-cycle implication
`define RSRC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define RSRC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/rsrc_pkg.sv -----
// shared constants, types and microcode table for the rotary slew rate controller
// no dependencies
`default_nettype none

package rsrc_pkg;

   localparam int FRACTION   = 1024;
   localparam int FRAC_BITS  = $clog2(FRACTION);
   localparam int MAX_FRAMES = 360;
   localparam int MIN_FRAMES = 8;

   localparam int FRM_W      = 9;
   localparam int POS_W      = FRM_W + FRAC_BITS;
   localparam int SPD_W      = 14;
   localparam int RATE_W     = 13;
   localparam int TURN_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = RATE_W;
   localparam int PC_W       = 3;

   localparam logic [TURN_W-1:0] TURN_NONE  = 2'd0;
   localparam logic [TURN_W-1:0] TURN_RIGHT = 2'd1;
   localparam logic [TURN_W-1:0] TURN_LEFT  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RATE    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL       = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRAKE       = 2'd3;

   localparam logic [FRM_W-1:0]  FRAME_COUNT_RST = 9'd40;
   localparam logic [RATE_W-1:0] MAX_RATE_RST    = 13'd1024;
   localparam logic [RATE_W-1:0] ACCEL_RST       = 13'd256;
   localparam logic [RATE_W-1:0] BRAKE_RST       = 13'd256;

   localparam logic [PC_W-1:0] PC_WAIT   = 3'd0;
   localparam logic [PC_W-1:0] PC_MOD    = 3'd1;
   localparam logic [PC_W-1:0] PC_SEL    = 3'd2;
   localparam logic [PC_W-1:0] PC_COAST  = 3'd3;
   localparam logic [PC_W-1:0] PC_SEEK   = 3'd4;
   localparam logic [PC_W-1:0] PC_UPDATE = 3'd5;
   localparam logic [PC_W-1:0] PC_EMIT   = 3'd6;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_WAIT,
      OP_MOD,
      OP_SEL,
      OP_COAST,
      OP_SEEK,
      OP_UPDATE,
      OP_EMIT
   } op_type;

   typedef enum logic [1:0] {
      BR_NEXT,
      BR_WAIT,
      BR_SKIP,
      BR_GOTO
   } br_type;

   typedef struct packed {
      op_type          op;
      br_type          br;
      logic [PC_W-1:0] tgt;
   } uword_type;

   typedef struct packed {
      logic [FRM_W-1:0]  frame_count;
      logic [RATE_W-1:0] max_rate;
      logic [RATE_W-1:0] accel;
      logic [RATE_W-1:0] brake;
   } cfg_type;

   function automatic uword_type ucode_rom(input logic [PC_W-1:0] addr);
      uword_type w;
      case (addr)
         PC_WAIT:   w = '{op: OP_WAIT,   br: BR_WAIT, tgt: PC_MOD};
         PC_MOD:    w = '{op: OP_MOD,    br: BR_WAIT, tgt: PC_SEL};
         PC_SEL:    w = '{op: OP_SEL,    br: BR_SKIP, tgt: PC_UPDATE};
         PC_COAST:  w = '{op: OP_COAST,  br: BR_WAIT, tgt: PC_SEEK};
         PC_SEEK:   w = '{op: OP_SEEK,   br: BR_NEXT, tgt: PC_UPDATE};
         PC_UPDATE: w = '{op: OP_UPDATE, br: BR_NEXT, tgt: PC_EMIT};
         PC_EMIT:   w = '{op: OP_EMIT,   br: BR_WAIT, tgt: PC_WAIT};
         default:   w = '{op: OP_NOP,    br: BR_GOTO, tgt: PC_WAIT};
      endcase
      return w;
   endfunction

endpackage

`default_nettype wire

// ----- design/rsrc_if.sv -----
// valid/ready channel interfaces: tick request, tick response, register write
// depends on rsrc_pkg
`default_nettype none

interface rsrc_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic [rsrc_pkg::TURN_W-1:0]      maneuver;
   logic [rsrc_pkg::FRM_W-1:0]       target_frame;

   modport source (output valid, opcode, maneuver, target_frame, input ready);
   modport sink   (input valid, opcode, maneuver, target_frame, output ready);
endinterface

interface rsrc_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [rsrc_pkg::POS_W-1:0]       position;
   logic signed [rsrc_pkg::SPD_W-1:0] speed;
   logic [rsrc_pkg::FRM_W-1:0]       frame_index;
   logic [rsrc_pkg::TURN_W-1:0]      applied_turn;
   logic [rsrc_pkg::TURN_W-1:0]      last_effect;

   modport source (output valid, position, speed, frame_index, applied_turn, last_effect,
                   input ready);
   modport sink   (input valid, position, speed, frame_index, applied_turn, last_effect,
                   output ready);
endinterface

interface rsrc_csr_if;
   logic                             valid;
   logic                             ready;
   logic [rsrc_pkg::CSR_IDX_W-1:0]   index;
   logic [rsrc_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ----- design/rotary_slew_rate_controller_core.sv -----
// tick steps: k frame wraps after frame_count is lowered (0 otherwise), then for a seek tick
//   m coasting steps, about |speed| / brake, one per cycle through the coast adder,
//   before the speed update and the response
// throughput: one transaction at a time, next request taken in the cycle after the response
//   is loaded into the output register; register writes taken every cycle
// reset: registers to defaults, heading at centre of frame zero, speed zero, no response
`default_nettype none

module rotary_slew_rate_controller_core (
   input  wire logic   clock,
   input  wire logic   reset,
   rsrc_req_if.sink    req_ch,
   rsrc_rsp_if.source  rsp_ch,
   rsrc_csr_if.sink    csr_ch
);

   rsrc_pkg::cfg_type cfg_ff, cfg_in;
   rsrc_pkg::op_type  op;
   logic              flag;

   assign csr_ch.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_ch.valid) begin
         case (csr_ch.index)
            rsrc_pkg::CSR_FRAME_COUNT: cfg_in.frame_count = csr_ch.data[rsrc_pkg::FRM_W-1:0];
            rsrc_pkg::CSR_MAX_RATE:    cfg_in.max_rate    = csr_ch.data;
            rsrc_pkg::CSR_ACCEL:       cfg_in.accel       = csr_ch.data;
            rsrc_pkg::CSR_BRAKE:       cfg_in.brake       = csr_ch.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_count <= rsrc_pkg::FRAME_COUNT_RST;
         cfg_ff.max_rate    <= rsrc_pkg::MAX_RATE_RST;
         cfg_ff.accel       <= rsrc_pkg::ACCEL_RST;
         cfg_ff.brake       <= rsrc_pkg::BRAKE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   rsrc_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flag  (flag),
      .op    (op)
   );

   rsrc_dp u_dp (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .cfg    (cfg_ff),
      .flag   (flag),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- design/rsrc_seq.sv -----
// microcode sequencer: step counter over the control table in rsrc_pkg
// depends on rsrc_pkg
`default_nettype none

module rsrc_seq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             flag,
   output rsrc_pkg::op_type      op
);

   logic [rsrc_pkg::PC_W-1:0] pc_ff;
   logic [rsrc_pkg::PC_W-1:0] pc_in;
   rsrc_pkg::uword_type       word;

   assign word = rsrc_pkg::ucode_rom(pc_ff);
   assign op   = word.op;

   always_comb begin
      case (word.br)
         rsrc_pkg::BR_NEXT: pc_in = pc_ff + rsrc_pkg::PC_W'(1);
         rsrc_pkg::BR_WAIT: pc_in = flag ? word.tgt : pc_ff;
         rsrc_pkg::BR_SKIP: pc_in = flag ? word.tgt : pc_ff + rsrc_pkg::PC_W'(1);
         rsrc_pkg::BR_GOTO: pc_in = word.tgt;
         default:           pc_in = rsrc_pkg::PC_WAIT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= rsrc_pkg::PC_WAIT;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/rsrc_dp.sv -----
// datapath: heading state, wrap reduction, coasting prediction, seek choice, speed update
// depends on rsrc_pkg and rsrc_if; driven one operation per cycle by rsrc_seq
`default_nettype none

module rsrc_dp (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire rsrc_pkg::op_type  op,
   input  wire rsrc_pkg::cfg_type cfg,
   output logic                 flag,
   rsrc_req_if.sink             req_ch,
   rsrc_rsp_if.source           rsp_ch
);

   localparam int POS_W  = rsrc_pkg::POS_W;
   localparam int SPD_W  = rsrc_pkg::SPD_W;
   localparam int FRM_W  = rsrc_pkg::FRM_W;
   localparam int FB     = rsrc_pkg::FRAC_BITS;
   localparam int TW     = rsrc_pkg::TURN_W;
   localparam int SUM_W  = POS_W + 2;
   localparam int ARW    = SPD_W + 2;

   function automatic logic [POS_W-1:0] wrap_pos(input logic signed [SUM_W-1:0] sum,
                                                 input logic [POS_W-1:0] span);
      logic signed [SUM_W-1:0] s_ext;
      logic signed [SUM_W-1:0] r;
      s_ext = signed'({2'b00, span});
      if (sum < 0) r = sum + s_ext;
      else if (sum >= s_ext) r = sum - s_ext;
      else r = sum;
      return r[POS_W-1:0];
   endfunction

   // heading state
   logic [POS_W-1:0]        pos_ff, pos_in;
   logic signed [SPD_W-1:0] spd_ff, spd_in;
   logic [TW-1:0]           eff_ff, eff_in;
   // work registers
   logic [FRM_W-1:0]        frm_ff, frm_in;
   logic [POS_W-1:0]        cp_ff, cp_in;
   logic signed [SPD_W-1:0] cs_ff, cs_in;
   logic [TW-1:0]           turn_ff, turn_in;
   logic                    opc_ff, opc_in;
   logic [TW-1:0]           man_ff, man_in;
   logic [FRM_W-1:0]        tgt_ff, tgt_in;
   // response register
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]        out_pos_ff, out_pos_in;
   logic signed [SPD_W-1:0] out_spd_ff, out_spd_in;
   logic [TW-1:0]           out_turn_ff, out_turn_in;
   logic [TW-1:0]           out_eff_ff, out_eff_in;

   logic [FRM_W-1:0]         frames;
   logic [POS_W-1:0]         span;
   logic [rsrc_pkg::RATE_W-1:0] brk;
   logic                     frm_ge;
   logic                     slot_free;

   logic                     cs_neg;
   logic [SPD_W-1:0]         cs_mag;
   logic                     coast_run;
   logic signed [SPD_W-1:0]  cs_next;
   logic [POS_W-1:0]         cp_wrap;

   logic [FRM_W-1:0]         cur, want, half, diff_up, diff_dn;
   logic [TW-1:0]            seek_turn, man_turn;

   logic signed [ARW-1:0]    s, n, mr, ac, br;
   logic [TW-1:0]            upd_eff;
   logic                     snap;
   logic [POS_W-1:0]         base;
   logic [POS_W-1:0]         upd_pos;

   always_comb begin
      if (cfg.frame_count < FRM_W'(rsrc_pkg::MIN_FRAMES)) frames = FRM_W'(rsrc_pkg::MIN_FRAMES);
      else if (cfg.frame_count > FRM_W'(rsrc_pkg::MAX_FRAMES))
         frames = FRM_W'(rsrc_pkg::MAX_FRAMES);
      else frames = cfg.frame_count;
   end

   assign span      = {frames, {FB{1'b0}}};
   assign brk       = (cfg.brake == '0) ? rsrc_pkg::RATE_W'(1) : cfg.brake;
   assign frm_ge    = frm_ff >= frames;
   assign slot_free = !rsp_valid_ff || rsp_ch.ready;

   // coasting prediction step
   assign cs_neg    = cs_ff[SPD_W-1];
   assign cs_mag    = cs_neg ? SPD_W'(-cs_ff) : SPD_W'(cs_ff);
   assign coast_run = cs_mag > {1'b0, brk};
   assign cs_next   = cs_neg ? cs_ff + signed'({1'b0, brk}) : cs_ff - signed'({1'b0, brk});
   assign cp_wrap   = wrap_pos(signed'({2'b00, cp_ff}) + SUM_W'(cs_next), span);

   // shorter turn toward the target frame
   assign cur     = cp_ff[POS_W-1:FB];
   assign want    = (tgt_ff >= frames) ? frames - FRM_W'(1) : tgt_ff;
   assign half    = frames >> 1;
   assign diff_up = want - cur;
   assign diff_dn = cur - want;

   always_comb begin
      if (cur == want) seek_turn = rsrc_pkg::TURN_NONE;
      else if (want > cur)
         seek_turn = (diff_up <= half) ? rsrc_pkg::TURN_RIGHT : rsrc_pkg::TURN_LEFT;
      else
         seek_turn = (diff_dn <= half) ? rsrc_pkg::TURN_LEFT : rsrc_pkg::TURN_RIGHT;
   end

   always_comb begin
      case (man_ff)
         rsrc_pkg::TURN_RIGHT: man_turn = rsrc_pkg::TURN_RIGHT;
         rsrc_pkg::TURN_LEFT:  man_turn = rsrc_pkg::TURN_LEFT;
         default:              man_turn = rsrc_pkg::TURN_NONE;
      endcase
   end

   // speed update
   assign s  = ARW'(spd_ff);
   assign mr = signed'({3'b000, cfg.max_rate});
   assign ac = signed'({3'b000, cfg.accel});
   assign br = signed'({3'b000, cfg.brake});

   always_comb begin
      n       = s;
      upd_eff = rsrc_pkg::TURN_NONE;
      snap    = 1'b0;
      case (turn_ff)
         rsrc_pkg::TURN_NONE: begin
            if (s != 0) begin
               if (s > 0) begin
                  n = s - br;
                  if (n < 0) n = '0;
                  upd_eff = rsrc_pkg::TURN_LEFT;
               end else begin
                  n = s + br;
                  if (n > 0) n = '0;
                  upd_eff = rsrc_pkg::TURN_RIGHT;
               end
               snap = (n == 0);
            end
         end
         rsrc_pkg::TURN_RIGHT: begin
            if (s < mr) begin
               n = s + ((s < 0) ? br : ac);
               if (n > mr) n = mr;
               upd_eff = rsrc_pkg::TURN_RIGHT;
            end
         end
         rsrc_pkg::TURN_LEFT: begin
            if (s > -mr) begin
               n = s - ((s > 0) ? br : ac);
               if (n < -mr) n = -mr;
               upd_eff = rsrc_pkg::TURN_LEFT;
            end
         end
         default: ;
      endcase
   end

   assign base    = snap ? {pos_ff[POS_W-1:FB], FB'(rsrc_pkg::FRACTION / 2)} : pos_ff;
   assign upd_pos = (n != 0) ? wrap_pos(signed'({2'b00, base}) + SUM_W'(n), span) : base;

   // status back to the sequencer
   always_comb begin
      case (op)
         rsrc_pkg::OP_WAIT:  flag = req_ch.valid;
         rsrc_pkg::OP_MOD:   flag = !frm_ge;
         rsrc_pkg::OP_SEL:   flag = !opc_ff;
         rsrc_pkg::OP_COAST: flag = !coast_run;
         rsrc_pkg::OP_EMIT:  flag = slot_free;
         default:            flag = 1'b0;
      endcase
   end

   always_comb begin
      pos_in      = pos_ff;
      spd_in      = spd_ff;
      eff_in      = eff_ff;
      frm_in      = frm_ff;
      cp_in       = cp_ff;
      cs_in       = cs_ff;
      turn_in     = turn_ff;
      opc_in      = opc_ff;
      man_in      = man_ff;
      tgt_in      = tgt_ff;
      out_pos_in  = out_pos_ff;
      out_spd_in  = out_spd_ff;
      out_turn_in = out_turn_ff;
      out_eff_in  = out_eff_ff;
      case (op)
         rsrc_pkg::OP_WAIT: begin
            if (req_ch.valid) begin
               opc_in = req_ch.opcode;
               man_in = req_ch.maneuver;
               tgt_in = req_ch.target_frame;
               frm_in = pos_ff[POS_W-1:FB];
            end
         end
         rsrc_pkg::OP_MOD: begin
            if (frm_ge) begin
               frm_in = frm_ff - frames;
            end else begin
               pos_in = {frm_ff, pos_ff[FB-1:0]};
               cp_in  = {frm_ff, pos_ff[FB-1:0]};
               cs_in  = spd_ff;
            end
         end
         rsrc_pkg::OP_SEL: turn_in = man_turn;
         rsrc_pkg::OP_COAST: begin
            if (coast_run) begin
               cs_in = cs_next;
               cp_in = cp_wrap;
            end
         end
         rsrc_pkg::OP_SEEK: turn_in = seek_turn;
         rsrc_pkg::OP_UPDATE: begin
            pos_in = upd_pos;
            spd_in = SPD_W'(n);
            eff_in = upd_eff;
         end
         rsrc_pkg::OP_EMIT: begin
            if (slot_free) begin
               out_pos_in  = pos_ff;
               out_spd_in  = spd_ff;
               out_turn_in = turn_ff;
               out_eff_in  = eff_ff;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = (op == rsrc_pkg::OP_EMIT && slot_free) ||
                         (rsp_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= POS_W'(rsrc_pkg::FRACTION / 2);
         spd_ff       <= '0;
         eff_ff       <= rsrc_pkg::TURN_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         spd_ff       <= spd_in;
         eff_ff       <= eff_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      frm_ff      <= frm_in;
      cp_ff       <= cp_in;
      cs_ff       <= cs_in;
      turn_ff     <= turn_in;
      opc_ff      <= opc_in;
      man_ff      <= man_in;
      tgt_ff      <= tgt_in;
      out_pos_ff  <= out_pos_in;
      out_spd_ff  <= out_spd_in;
      out_turn_ff <= out_turn_in;
      out_eff_ff  <= out_eff_in;
   end

   assign req_ch.ready        = (op == rsrc_pkg::OP_WAIT);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.position     = out_pos_ff;
   assign rsp_ch.speed        = out_spd_ff;
   assign rsp_ch.frame_index  = out_pos_ff[POS_W-1:FB];
   assign rsp_ch.applied_turn = out_turn_ff;
   assign rsp_ch.last_effect  = out_eff_ff;

endmodule

`default_nettype wire

// ----- design/rsrc_chk.sv -----
// port-level checker for the rotary slew rate controller, bound to the top level
// depends on rsrc_pkg and rotary_slew_rate_controller_core_defines.svh
`default_nettype none
`include "rotary_slew_rate_controller_core_defines.svh"

module rsrc_chk (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [rsrc_pkg::POS_W-1:0]        rsp_position,
   input wire logic signed [rsrc_pkg::SPD_W-1:0] rsp_speed,
   input wire logic [rsrc_pkg::TURN_W-1:0]       rsp_applied_turn,
   input wire logic [rsrc_pkg::TURN_W-1:0]       rsp_last_effect
);

   `RSRC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped while stalled")
   `RSRC_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken twice in a row")
   `RSRC_ASSERT_NOW(a_snap_centre, rsp_valid && rsp_applied_turn == rsrc_pkg::TURN_NONE && rsp_last_effect != rsrc_pkg::TURN_NONE && rsp_speed == 0, rsp_position[rsrc_pkg::FRAC_BITS-1:0] == rsrc_pkg::FRAC_BITS'(rsrc_pkg::FRACTION / 2), "stop without snap to frame centre")
   `RSRC_ASSERT_NOW(a_coast_effect, rsp_valid && rsp_applied_turn == rsrc_pkg::TURN_NONE && rsp_speed != 0, rsp_last_effect != rsrc_pkg::TURN_NONE, "moving coast with no braking effect")

endmodule

bind rotary_slew_rate_controller_core rsrc_chk u_rsrc_chk (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_ch.valid),
   .req_ready        (req_ch.ready),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_position     (rsp_ch.position),
   .rsp_speed        (rsp_ch.speed),
   .rsp_applied_turn (rsp_ch.applied_turn),
   .rsp_last_effect  (rsp_ch.last_effect)
);

`default_nettype wire

// ----- tb/rotary_slew_rate_controller_core_test.sv -----
// self-checking testbench for rotary_slew_rate_controller_core: directed and random ticks
// checks every response against an in-bench heading predictor
// depends on rsrc_pkg, rsrc_if and the core

module rotary_slew_rate_controller_core_test;

   localparam int POS_W      = rsrc_pkg::POS_W;
   localparam int SPD_W      = rsrc_pkg::SPD_W;
   localparam int FRM_W      = rsrc_pkg::FRM_W;
   localparam int TURN_W     = rsrc_pkg::TURN_W;
   localparam int CSR_IDX_W  = rsrc_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W = rsrc_pkg::CSR_DATA_W;
   localparam int FRACTION   = rsrc_pkg::FRACTION;

   localparam logic OPC_MANUAL = 1'b0;
   localparam logic OPC_SEEK   = 1'b1;
   localparam int   STALL_LIMIT = 30000;
   localparam int   REPORT_LIMIT = 60;

   typedef struct {
      logic [POS_W-1:0]         position;
      logic signed [SPD_W-1:0]  speed;
      logic [FRM_W-1:0]         frame_index;
      logic [TURN_W-1:0]        applied_turn;
      logic [TURN_W-1:0]        last_effect;
   } tick_result_type;

   logic clock;
   logic reset;

   rsrc_req_if req_ch();
   rsrc_rsp_if rsp_ch();
   rsrc_csr_if csr_ch();

   rotary_slew_rate_controller_core dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // heading predictor state and register shadow
   rsrc_pkg::cfg_type reg_shadow;
   int                heading_fine;
   int                spin_rate;
   logic [TURN_W-1:0] last_thrust;

   tick_result_type pending_headings[$];
   int  mismatch_count;
   int  idle_cycles;
   bit  req_gaps_on;
   bit  rsp_stalls_on;
   int  rsp_stall_left;
   int  rsp_hold_left;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 60);
   endfunction

   function automatic int active_frames();
      int f;
      f = int'(reg_shadow.frame_count);
      if (f < rsrc_pkg::MIN_FRAMES) f = rsrc_pkg::MIN_FRAMES;
      if (f > rsrc_pkg::MAX_FRAMES) f = rsrc_pkg::MAX_FRAMES;
      return f;
   endfunction

   function automatic int wrap_turn(input int p, input int span_len);
      int r;
      r = p % span_len;
      if (r < 0) r += span_len;
      return r;
   endfunction

   // where the heading would settle if it coasted from here
   function automatic int coast_settle(input int span_len);
      int p;
      int s;
      int b;
      p = heading_fine;
      s = spin_rate;
      b = (reg_shadow.brake == '0) ? 1 : int'(reg_shadow.brake);
      while (s > b || s < -b) begin
         if (s > 0) begin
            s -= b;
            if (s < 0) s = 0;
         end else begin
            s += b;
            if (s > 0) s = 0;
         end
         if (s != 0) p = wrap_turn(p + s, span_len);
      end
      return p;
   endfunction

   function automatic logic [TURN_W-1:0] seek_direction(input int frames, input int span_len,
                                                        input int tgt);
      int cur;
      int want;
      int diff;
      cur = coast_settle(span_len) / FRACTION;
      want = (tgt >= frames) ? frames - 1 : tgt;
      if (cur == want) return rsrc_pkg::TURN_NONE;
      diff = want - cur;
      if (diff > 0) return (diff <= frames / 2) ? rsrc_pkg::TURN_RIGHT : rsrc_pkg::TURN_LEFT;
      return (-diff <= frames / 2) ? rsrc_pkg::TURN_LEFT : rsrc_pkg::TURN_RIGHT;
   endfunction

   function automatic tick_result_type next_heading(input logic op,
                                                    input logic [TURN_W-1:0] man,
                                                    input logic [FRM_W-1:0] tgt);
      int frames;
      int span_len;
      int mr;
      int ac;
      int br;
      logic [TURN_W-1:0] turn;
      tick_result_type r;
      frames = active_frames();
      span_len = frames * FRACTION;
      mr = int'(reg_shadow.max_rate);
      ac = int'(reg_shadow.accel);
      br = int'(reg_shadow.brake);
      if (heading_fine >= span_len || heading_fine < 0)
         heading_fine = wrap_turn(heading_fine, span_len);
      if (op == OPC_SEEK)
         turn = seek_direction(frames, span_len, int'(tgt));
      else if (man == rsrc_pkg::TURN_RIGHT || man == rsrc_pkg::TURN_LEFT)
         turn = man;
      else
         turn = rsrc_pkg::TURN_NONE;
      case (turn)
         rsrc_pkg::TURN_NONE: begin
            if (spin_rate > 0) begin
               spin_rate -= br;
               if (spin_rate < 0) spin_rate = 0;
               last_thrust = rsrc_pkg::TURN_LEFT;
            end else if (spin_rate < 0) begin
               spin_rate += br;
               if (spin_rate > 0) spin_rate = 0;
               last_thrust = rsrc_pkg::TURN_RIGHT;
            end else begin
               last_thrust = rsrc_pkg::TURN_NONE;
            end
            // snap to frame centre once stopped
            if (spin_rate == 0 && last_thrust != rsrc_pkg::TURN_NONE)
               heading_fine = (heading_fine / FRACTION) * FRACTION + FRACTION / 2;
         end
         rsrc_pkg::TURN_RIGHT: begin
            if (spin_rate < mr) begin
               spin_rate += (spin_rate < 0) ? br : ac;
               if (spin_rate > mr) spin_rate = mr;
               last_thrust = rsrc_pkg::TURN_RIGHT;
            end else begin
               last_thrust = rsrc_pkg::TURN_NONE;
            end
         end
         default: begin
            if (spin_rate > -mr) begin
               spin_rate -= (spin_rate > 0) ? br : ac;
               if (spin_rate < -mr) spin_rate = -mr;
               last_thrust = rsrc_pkg::TURN_LEFT;
            end else begin
               last_thrust = rsrc_pkg::TURN_NONE;
            end
         end
      endcase
      if (spin_rate != 0) heading_fine = wrap_turn(heading_fine + spin_rate, span_len);
      r.position = heading_fine[POS_W-1:0];
      r.speed = spin_rate[SPD_W-1:0];
      r.frame_index = FRM_W'(heading_fine / FRACTION);
      r.applied_turn = turn;
      r.last_effect = last_thrust;
      return r;
   endfunction

   // sender: entered and left at a falling edge
   task automatic issue_tick(input logic op, input logic [TURN_W-1:0] man,
                             input logic [FRM_W-1:0] tgt);
      int gap;
      gap = req_gaps_on ? pick_gap() : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.maneuver <= man;
      req_ch.target_frame <= tgt;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      pending_headings.push_back(next_heading(op, man, tgt));
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] value);
      csr_ch.valid <= 1'b1;
      csr_ch.index <= idx;
      csr_ch.data <= value;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      case (idx)
         rsrc_pkg::CSR_FRAME_COUNT: reg_shadow.frame_count = value[FRM_W-1:0];
         rsrc_pkg::CSR_MAX_RATE:    reg_shadow.max_rate = value;
         rsrc_pkg::CSR_ACCEL:       reg_shadow.accel = value;
         rsrc_pkg::CSR_BRAKE:       reg_shadow.brake = value;
         default: ;
      endcase
      @(negedge clock);
   endtask

   task automatic set_config(input logic [CSR_DATA_W-1:0] fc, input logic [CSR_DATA_W-1:0] mr,
                             input logic [CSR_DATA_W-1:0] ac, input logic [CSR_DATA_W-1:0] br);
      write_reg(rsrc_pkg::CSR_FRAME_COUNT, fc);
      write_reg(rsrc_pkg::CSR_MAX_RATE, mr);
      write_reg(rsrc_pkg::CSR_ACCEL, ac);
      write_reg(rsrc_pkg::CSR_BRAKE, br);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (pending_headings.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic check_reset_state();
      issue_tick(OPC_MANUAL, rsrc_pkg::TURN_NONE, '0);
      issue_tick(OPC_SEEK, rsrc_pkg::TURN_NONE, '0);
   endtask

   task automatic check_manual_turns();
      repeat (5) issue_tick(OPC_MANUAL, rsrc_pkg::TURN_RIGHT, '0);
      issue_tick(OPC_MANUAL, rsrc_pkg::TURN_LEFT, '0);
      issue_tick(OPC_MANUAL, 2'd3, 9'h1FF);
      repeat (2) issue_tick(OPC_MANUAL, rsrc_pkg::TURN_NONE, '0);
   endtask

   task automatic check_seek_choice();
      issue_tick(OPC_SEEK, rsrc_pkg::TURN_NONE, 9'd20);
      issue_tick(OPC_SEEK, 2'd3, 9'd21);
      issue_tick(OPC_SEEK, rsrc_pkg::TURN_LEFT, 9'h1FF);
      issue_tick(OPC_MANUAL, rsrc_pkg::TURN_RIGHT, '0);
      issue_tick(OPC_SEEK, rsrc_pkg::TURN_RIGHT, 9'd0);
      wait_idle();
   endtask

   // oversized frame count, top rates, then a shrunken turn with a zero speed limit
   task automatic check_wide_and_shrunk_turn();
      set_config(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
      repeat (3) issue_tick(OPC_MANUAL, rsrc_pkg::TURN_RIGHT, '0);
      wait_idle();
      set_config(13'd0, 13'd0, 13'h1FFF, 13'h1FFF);
      issue_tick(OPC_MANUAL, rsrc_pkg::TURN_NONE, '0);
      issue_tick(OPC_MANUAL, rsrc_pkg::TURN_RIGHT, '0);
      wait_idle();
   endtask

   task automatic check_zero_brake();
      set_config(13'd40, 13'd300, 13'd100, 13'd0);
      repeat (2) issue_tick(OPC_MANUAL, rsrc_pkg::TURN_RIGHT, '0);
      issue_tick(OPC_SEEK, rsrc_pkg::TURN_NONE, 9'd5);
      issue_tick(OPC_MANUAL, rsrc_pkg::TURN_NONE, '0);
      wait_idle();
   endtask

   // response side held off while requests keep coming
   task automatic check_output_backpressure();
      set_config(13'd40, 13'd1024, 13'd256, 13'd256);
      req_gaps_on = 1'b0;
      rsp_hold_left = 400;
      repeat (3) issue_tick(OPC_MANUAL, rsrc_pkg::TURN_LEFT, '0);
      repeat (3) issue_tick(OPC_SEEK, rsrc_pkg::TURN_NONE, 9'd30);
      wait_idle();
   endtask

   task automatic run_random_phase(input logic [CSR_DATA_W-1:0] fc,
                                   input logic [CSR_DATA_W-1:0] mr,
                                   input logic [CSR_DATA_W-1:0] ac,
                                   input logic [CSR_DATA_W-1:0] br,
                                   input int count, input bit gaps_on);
      int done;
      int burst;
      int kind;
      bit paused;
      logic [FRM_W-1:0] tgt;
      logic [TURN_W-1:0] man;
      wait_idle();
      set_config(fc, mr, ac, br);
      req_gaps_on = gaps_on;
      rsp_stalls_on = gaps_on;
      done = 0;
      paused = 1'b0;
      while (done < count) begin
         if (!paused && done >= count / 2) begin
            wait_idle();
            paused = 1'b1;
         end
         kind = $urandom_range(0, 9);
         if (kind < 6) begin
            burst = $urandom_range(3, 25);
            if (burst > count - done) burst = count - done;
            if ($urandom_range(0, 7) == 0) tgt = FRM_W'($urandom_range(0, 511));
            else tgt = FRM_W'($urandom_range(0, active_frames() - 1));
            repeat (burst) issue_tick(OPC_SEEK, TURN_W'($urandom_range(0, 3)), tgt);
         end else if (kind < 8) begin
            burst = $urandom_range(1, 12);
            if (burst > count - done) burst = count - done;
            man = TURN_W'($urandom_range(0, 3));
            repeat (burst) issue_tick(OPC_MANUAL, man, FRM_W'($urandom_range(0, 511)));
         end else begin
            burst = 1;
            issue_tick(1'($urandom_range(0, 1)), TURN_W'($urandom_range(0, 3)),
                       FRM_W'($urandom_range(0, 511)));
         end
         done += burst;
      end
   endtask

   task automatic run_random_phases();
      int mr;
      run_random_phase(13'd40, 13'd1024, 13'd256, 13'd256, 150, 1'b1);
      run_random_phase(13'd8, 13'd1, 13'd1, 13'd1, 80, 1'b1);
      run_random_phase(13'd360, 13'h1FFF, 13'h1FFF, 13'h1FFF, 100, 1'b0);
      run_random_phase(13'd359, 13'h1FFF, 13'h1FFF, 13'd1, 12, 1'b1);
      run_random_phase(13'h1FF, 13'd2000, 13'd300, 13'd64, 120, 1'b1);
      run_random_phase(13'd9, 13'd500, 13'd3, 13'd0, 60, 1'b1);
      run_random_phase(13'd0, 13'd0, 13'h1FFF, 13'h1FFF, 40, 1'b0);
      run_random_phase(13'd100, 13'd4000, 13'd0, 13'd500, 50, 1'b1);
      repeat (4) begin
         mr = $urandom_range(0, 8191);
         run_random_phase(CSR_DATA_W'($urandom_range(0, 511)), CSR_DATA_W'(mr),
                          CSR_DATA_W'($urandom_range(0, 8191)),
                          CSR_DATA_W'($urandom_range(mr / 64 + 1, 8191)), 110, 1'b1);
      end
   endtask

   // response sink
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         if (rsp_stalls_on && $urandom_range(0, 4) == 0) rsp_stall_left = pick_gap();
      end
   end

   function automatic bit check_field(input string name, input int want_v, input int got_v,
                                      input bit report);
      if (want_v == got_v) return 1'b0;
      if (report) $error("%s: expected %0d, got %0d", name, want_v, got_v);
      return 1'b1;
   endfunction

   always @(posedge clock) begin
      tick_result_type want;
      bit bad;
      bit report;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         report = mismatch_count < REPORT_LIMIT;
         if (pending_headings.size() == 0) begin
            if (report) $error("response transaction with no tick outstanding");
            mismatch_count++;
         end else begin
            want = pending_headings.pop_front();
            bad = check_field("position", int'(want.position), int'(rsp_ch.position),
                              report);
            bad |= check_field("speed", int'(want.speed), int'(rsp_ch.speed), report);
            bad |= check_field("frame_index", int'(want.frame_index),
                               int'(rsp_ch.frame_index), report);
            bad |= check_field("applied_turn", int'(want.applied_turn),
                               int'(rsp_ch.applied_turn), report);
            bad |= check_field("last_effect", int'(want.last_effect),
                               int'(rsp_ch.last_effect), report);
            if (bad) mismatch_count++;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_ch.valid = 1'b0;
      req_ch.opcode = OPC_MANUAL;
      req_ch.maneuver = rsrc_pkg::TURN_NONE;
      req_ch.target_frame = '0;
      rsp_ch.ready = 1'b0;
      csr_ch.valid = 1'b0;
      csr_ch.index = rsrc_pkg::CSR_FRAME_COUNT;
      csr_ch.data = '0;
      reg_shadow = '{rsrc_pkg::FRAME_COUNT_RST, rsrc_pkg::MAX_RATE_RST, rsrc_pkg::ACCEL_RST,
                     rsrc_pkg::BRAKE_RST};
      heading_fine = FRACTION / 2;
      spin_rate = 0;
      last_thrust = rsrc_pkg::TURN_NONE;
      mismatch_count = 0;
      idle_cycles = 0;
      req_gaps_on = 1'b1;
      rsp_stalls_on = 1'b1;
      rsp_stall_left = 0;
      rsp_hold_left = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      check_reset_state();
      check_manual_turns();
      check_seek_choice();
      check_wide_and_shrunk_turn();
      check_zero_brake();
      check_output_backpressure();
      run_random_phases();

      req_ch.valid <= 1'b0;
      while (pending_headings.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
